[rtl/tbhc_pkg.sv]
// Shared types and constants for the text byte hygiene checker.
// No dependencies; used by tbhc_scan, tbhc_queue and the top level.
package tbhc_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] KIND_CR_NO_LF = 2'd0;
  localparam logic [1:0] KIND_HIGH     = 2'd1;
  localparam logic [1:0] KIND_CONTROL  = 2'd2;
  localparam logic [1:0] KIND_SUMMARY  = 2'd3;

  localparam int FLAG_UNIX_BIT = 0;
  localparam int FLAG_DOS_BIT  = 1;

  typedef struct packed {
    logic        last_of_run;
    logic        ends_with_newline;
    logic [1:0]  ending_mode;
    logic [31:0] column_number;
    logic [31:0] line_number;
    logic [7:0]  event_byte;
    logic [1:0]  event_kind;
  } res_t;

  // Up to two results handed together from the scanner to the output queue.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

[rtl/text_byte_hygiene_checker.sv]
// Top level of the text byte hygiene checker: stream ports, scanner, result queue.
// Depends on tbhc_pkg, tbhc_scan and tbhc_queue.
//
// Channel   Dir  tdata                                   tuser        tlast
// s_axis    in   [7:0] data_byte                         [0] cmd      -
// m_axis    out  [7:0] event_byte, [39:8] line_number,   [1:0] kind   last_of_run
//                [71:40] column_number, [73:72] ending_mode,
//                [74] ends_with_newline, [79:75] zero
//
// One input item per cycle while the queue has room for its results: an
// item is registered on accept, classified in the next cycle and its zero,
// one or two results pushed into a two-entry queue. The output port moves
// one item per cycle while m_tready is high, so items that make two results
// (a lone CR followed by a reported byte, or an end of stream after a CR)
// can hold back the following input item. Synchronous reset empties the
// input register and the queue and returns line and column to 1. A stall on
// m_axis fills the queue and then drops s_tready; nothing is lost.
module text_byte_hygiene_checker #(
  parameter int COUNT_BITS = tbhc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // event_byte, line_number, column_number,
                                 // ending_mode, ends_with_newline, zero pad
  output logic [1:0]  m_tuser,   // [1:0] event_kind
  output logic        m_tlast    // last_of_run
);

  tbhc_pkg::push_t push;
  tbhc_pkg::res_t  res;
  logic [1:0]      room;

  tbhc_scan #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_byte  (s_tdata),
    .room     (room),
    .push     (push)
  );

  tbhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {5'd0, res.ends_with_newline, res.ending_mode, res.column_number,
                    res.line_number, res.event_byte};
  assign m_tuser = res.event_kind;
  assign m_tlast = res.last_of_run;

endmodule

[rtl/tbhc_scan.sv]
// Input register, stream state and per-item result generation.
// Depends on tbhc_pkg.
module tbhc_scan #(
  parameter int COUNT_BITS = tbhc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte,
  input  logic [1:0]        room,
  output tbhc_pkg::push_t   push
);

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  held;
  logic                  cmd;
  logic [7:0]            byte_r;
  logic [COUNT_BITS-1:0] line_count;
  logic [COUNT_BITS-1:0] column_count;
  logic [7:0]            previous_byte;
  logic [1:0]            mode_flags;

  logic                  prev_cr;
  logic                  is_lf;
  logic                  is_high;
  logic                  is_ctrl;
  logic                  is_evt;
  logic [1:0]            n;
  logic                  advance;
  logic [31:0]           line_out;
  logic [31:0]           col_out;
  logic [31:0]           col_cr_out;
  tbhc_pkg::res_t        cr_res;
  tbhc_pkg::res_t        evt_res;
  tbhc_pkg::res_t        sum_res;

  // Clip a counter to 32 bits, whatever COUNT_BITS is.
  function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  assign prev_cr = (previous_byte == tbhc_pkg::BYTE_CR);
  assign is_lf   = (byte_r == tbhc_pkg::BYTE_LF);
  assign is_high = byte_r[7];
  assign is_ctrl = ((byte_r == tbhc_pkg::BYTE_DEL) || (byte_r < tbhc_pkg::BYTE_SPACE)) &&
                   (byte_r != tbhc_pkg::BYTE_CR) && (byte_r != tbhc_pkg::BYTE_TAB);
  assign is_evt  = is_high || is_ctrl;

  assign line_out   = clip32(line_count);
  assign col_out    = clip32(column_count);
  assign col_cr_out = clip32(column_count - CNT_ONE);

  always_comb begin
    cr_res = '0;
    cr_res.event_kind    = tbhc_pkg::KIND_CR_NO_LF;
    cr_res.line_number   = line_out;
    cr_res.column_number = col_cr_out;
    cr_res.last_of_run   = (cmd == tbhc_pkg::CMD_DATA) && !is_evt;

    evt_res = '0;
    evt_res.event_kind    = is_high ? tbhc_pkg::KIND_HIGH : tbhc_pkg::KIND_CONTROL;
    evt_res.event_byte    = byte_r;
    evt_res.line_number   = line_out;
    evt_res.column_number = col_out;
    evt_res.last_of_run   = 1'b1;

    sum_res = '0;
    sum_res.event_kind        = tbhc_pkg::KIND_SUMMARY;
    sum_res.line_number       = line_out;
    sum_res.column_number     = col_out;
    sum_res.ending_mode       = mode_flags;
    sum_res.ends_with_newline = (previous_byte == tbhc_pkg::BYTE_LF);
    sum_res.last_of_run       = 1'b1;
  end

  always_comb begin
    push.r0 = cr_res;
    push.r1 = sum_res;
    n = 2'd0;
    if (cmd == tbhc_pkg::CMD_END) begin
      n       = prev_cr ? 2'd2 : 2'd1;
      push.r0 = prev_cr ? cr_res : sum_res;
      push.r1 = sum_res;
    end else if (!is_lf) begin
      n       = 2'(prev_cr) + 2'(is_evt);
      push.r0 = prev_cr ? cr_res : evt_res;
      push.r1 = evt_res;
    end
    advance  = held && (n <= room);
    push.n   = advance ? n : 2'd0;
    in_ready = !held || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      cmd    <= in_cmd;
      byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= CNT_ONE;
      column_count  <= CNT_ONE;
      previous_byte <= 8'd0;
      mode_flags    <= 2'd0;
    end else if (advance) begin
      if (cmd == tbhc_pkg::CMD_END) begin
        line_count    <= CNT_ONE;
        column_count  <= CNT_ONE;
        previous_byte <= 8'd0;
        mode_flags    <= 2'd0;
      end else begin
        previous_byte <= byte_r;
        if (is_lf) begin
          if (prev_cr) begin
            mode_flags[tbhc_pkg::FLAG_DOS_BIT] <= 1'b1;
          end else begin
            mode_flags[tbhc_pkg::FLAG_UNIX_BIT] <= 1'b1;
          end
          line_count   <= sat_inc(line_count);
          column_count <= CNT_ONE;
        end else begin
          column_count <= sat_inc(column_count);
        end
      end
    end
  end

endmodule

[rtl/tbhc_queue.sv]
// Two-entry result queue; takes up to two results per cycle, gives one while out_ready is high.
// Depends on tbhc_pkg.
module tbhc_queue (
  input  logic            clk,
  input  logic            rst,
  input  tbhc_pkg::push_t push,
  output logic [1:0]      room,
  output logic            out_valid,
  input  logic            out_ready,
  output tbhc_pkg::res_t  out_res
);

  logic [1:0]     count;
  logic [1:0]     count_next;
  logic [1:0]     count_kept;
  logic           pop;
  tbhc_pkg::res_t slot0;
  tbhc_pkg::res_t slot1;
  tbhc_pkg::res_t slot0_next;
  tbhc_pkg::res_t slot1_next;

  assign out_valid = (count != 2'd0);
  assign out_res   = slot0;
  assign pop       = out_valid && out_ready;

  // Free slots after this cycle's pop.
  assign room = 2'(tbhc_pkg::QUEUE_DEPTH) - count + 2'(pop);

  always_comb begin
    count_kept = count - 2'(pop);
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    if (count_kept == 2'd0) begin
      if (push.n != 2'd0) begin
        slot0_next = push.r0;
      end
      if (push.n == 2'd2) begin
        slot1_next = push.r1;
      end
    end else if (count_kept == 2'd1) begin
      if (push.n != 2'd0) begin
        slot1_next = push.r0;
      end
    end
    count_next = count_kept + push.n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule
